>>> sv/cttap_pkg.sv
// Shared types, character codes and helpers for the caret tag text attribute parser.
// No dependencies; used by cttap_parse and the top level.
`timescale 1ns / 1ps

package cttap_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ColorWidth = 32;
   localparam int unsigned FlashWidth = 5;
   localparam int unsigned HexWidth   = 24;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned ModeWidth  = 2;

   localparam logic [ColorWidth-1:0] DEFAULT_COLOR_RESET = 32'hFFFF_FFFF;
   localparam logic [ModeWidth-1:0]  MODE_LITERAL = 2'd0;
   localparam logic [ModeWidth-1:0]  MODE_STRIP   = 2'd1;
   localparam logic [ModeWidth-1:0]  MODE_APPLY   = 2'd2;

   localparam logic CSR_TAG_MODE      = 1'b0;
   localparam logic CSR_DEFAULT_COLOR = 1'b1;

   localparam logic [CountWidth-1:0] COLOR_DIGITS = 3'd6;
   localparam logic [CountWidth-1:0] ALPHA_DIGITS = 3'd2;
   localparam logic [3:0]            FLASH_MAX    = 4'd9;

   localparam logic [ByteWidth-1:0] CH_TAB   = 8'h09;
   localparam logic [ByteWidth-1:0] CH_CARET = 8'h5E;
   localparam logic [ByteWidth-1:0] CH_0     = 8'h30;
   localparam logic [ByteWidth-1:0] CH_9     = 8'h39;
   localparam logic [ByteWidth-1:0] CH_LA    = 8'h61;
   localparam logic [ByteWidth-1:0] CH_LF    = 8'h66;
   localparam logic [ByteWidth-1:0] CH_UA    = 8'h41;
   localparam logic [ByteWidth-1:0] CH_UF    = 8'h46;
   localparam logic [ByteWidth-1:0] TAG_COLOR     = 8'h63; // c
   localparam logic [ByteWidth-1:0] TAG_ALPHA     = 8'h61; // a
   localparam logic [ByteWidth-1:0] TAG_FLASH     = 8'h66; // f
   localparam logic [ByteWidth-1:0] TAG_RESET     = 8'h72; // r
   localparam logic [ByteWidth-1:0] TAG_NOP       = 8'h6F; // o
   localparam logic [ByteWidth-1:0] TAG_BOLD      = 8'h62; // b
   localparam logic [ByteWidth-1:0] TAG_ITALIC    = 8'h69; // i
   localparam logic [ByteWidth-1:0] TAG_RGB_DEF   = 8'h43; // C
   localparam logic [ByteWidth-1:0] TAG_ALPHA_DEF = 8'h41; // A
   localparam logic [ByteWidth-1:0] TAG_FLASH_OFF = 8'h46; // F
   localparam logic [ByteWidth-1:0] TAG_BOLD_OFF  = 8'h42; // B
   localparam logic [ByteWidth-1:0] TAG_ITAL_OFF  = 8'h49; // I

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_CARET,
      PH_COLOR,
      PH_ALPHA,
      PH_FLASH,
      PH_HALT
   } phase_type;

   typedef struct packed {
      logic                  found;
      logic [3:0]            value;
   } hex_type;

   typedef struct packed {
      logic                  italic_on;
      logic                  bold_on;
      logic [FlashWidth-1:0] flash_rate;
      logic [ColorWidth-1:0] blend_color;
      logic [ByteWidth-1:0]  glyph_code;
   } glyph_type;

   typedef struct packed {
      logic                 step;
      logic                 last;
      logic [ByteWidth-1:0] text_byte;
   } item_type;

   function automatic hex_type hex_digit(input logic [ByteWidth-1:0] b);
      hex_type h;
      h.found = 1'b1;
      h.value = 4'd0;
      if (b >= CH_0 && b <= CH_9) begin
         h.value = b[3:0];
      end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
         h.value = b[3:0] + 4'd9;
      end else begin
         h.found = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [FlashWidth-1:0] flash_of(input logic [ByteWidth-1:0] b);
      logic [3:0] d;
      if (b < CH_0) begin
         d = 4'd0;
      end else if (b > CH_9) begin
         d = FLASH_MAX;
      end else begin
         d = b[3:0];
      end
      return {d, 1'b1};
   endfunction

endpackage

>>> sv/caret_tag_text_attribute_parser_core.sv
// Caret tag text attribute parser: stream top level with input and result registers.
// Depends on cttap_pkg and cttap_parse.
// A visible glyph passes the input register, then the result register that drives rsp_tvalid.
// Throughput: one byte per cycle unless rsp_tready stalls; the update is combinational.
// Reset: synchronous; tag_mode to apply, default colour to all ones, string state cleared.
`timescale 1ns / 1ps

module caret_tag_text_attribute_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // glyph_code, blend_color, flash_rate, bold_on, italic_on
   output logic        rsp_tlast,   // from_final_byte
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic                                in_valid_ff, in_valid_in;
   logic [cttap_pkg::ByteWidth-1:0]     in_byte_ff;
   logic                                in_last_ff;
   logic                                out_valid_ff, out_valid_in;
   cttap_pkg::glyph_type                out_glyph_ff;
   logic                                out_last_ff;
   logic [cttap_pkg::ModeWidth-1:0]     tag_mode_ff;
   logic [cttap_pkg::ColorWidth-1:0]    default_color_ff;
   logic                                advance;
   cttap_pkg::item_type                 item;
   logic                                emit;
   cttap_pkg::glyph_type                glyph;
   logic                                in_string;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign item.step      = in_valid_ff && advance;
   assign item.last      = in_last_ff;
   assign item.text_byte = in_byte_ff;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = item.step ? emit : (advance ? 1'b0 : out_valid_ff);

   cttap_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .item          (item),
      .tag_mode      (tag_mode_ff),
      .default_color (default_color_ff),
      .emit          (emit),
      .glyph         (glyph),
      .in_string     (in_string)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         tag_mode_ff      <= cttap_pkg::MODE_APPLY;
         default_color_ff <= cttap_pkg::DEFAULT_COLOR_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_index == cttap_pkg::CSR_TAG_MODE) begin
            tag_mode_ff <= csr_wdata[cttap_pkg::ModeWidth-1:0];
         end
         if (csr_valid && csr_index == cttap_pkg::CSR_DEFAULT_COLOR) begin
            default_color_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (item.step && emit) begin
         out_glyph_ff <= glyph;
         out_last_ff  <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_glyph_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input word lost while stalled");
   a_flash_odd: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_glyph_ff.flash_rate[0] || out_glyph_ff.flash_rate == '0))
      else $error("even flash rate");
   a_flash_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_glyph_ff.flash_rate <= 5'd19)
      else $error("flash rate above range");
   a_fresh_after_reset: assert property (@(posedge clock)
      reset |=> !in_string)
      else $error("string state survived reset");
`endif

endmodule

>>> sv/cttap_parse.sv
// Tag parser state and per-byte attribute update for one registered text byte.
// Depends on cttap_pkg.
`timescale 1ns / 1ps

module cttap_parse (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cttap_pkg::item_type                  item,
   input  logic [cttap_pkg::ModeWidth-1:0]      tag_mode,
   input  logic [cttap_pkg::ColorWidth-1:0]     default_color,
   output logic                                 emit,
   output cttap_pkg::glyph_type                 glyph,
   output logic                                 in_string
);

   cttap_pkg::phase_type                phase_ff, phase_in, phase_cur;
   logic [cttap_pkg::CountWidth-1:0]    count_ff, count_in, count_cur, count_inc;
   logic [cttap_pkg::HexWidth-1:0]      acc_ff, acc_in, acc_cur, acc_hex;
   logic                                run_ff, run_in, run_cur, run_hex;
   logic [cttap_pkg::ColorWidth-1:0]    color_ff, color_in, color_cur;
   logic [cttap_pkg::FlashWidth-1:0]    flash_ff, flash_in, flash_cur;
   logic                                bold_ff, bold_in, bold_cur;
   logic                                italic_ff, italic_in, italic_cur;
   logic                                in_string_ff, in_string_in;
   logic                                parse, apply;
   cttap_pkg::hex_type                  hex;

   assign in_string = in_string_ff;
   assign parse = (tag_mode != cttap_pkg::MODE_LITERAL);
   assign apply = (tag_mode != cttap_pkg::MODE_LITERAL) && (tag_mode != cttap_pkg::MODE_STRIP);

   // reload attributes at the start of a string
   assign phase_cur  = in_string_ff ? phase_ff  : cttap_pkg::PH_NORMAL;
   assign count_cur  = in_string_ff ? count_ff  : '0;
   assign acc_cur    = in_string_ff ? acc_ff    : '0;
   assign run_cur    = in_string_ff ? run_ff    : 1'b1;
   assign color_cur  = in_string_ff ? color_ff  : default_color;
   assign flash_cur  = in_string_ff ? flash_ff  : '0;
   assign bold_cur   = in_string_ff ? bold_ff   : 1'b0;
   assign italic_cur = in_string_ff ? italic_ff : 1'b0;

   assign hex       = cttap_pkg::hex_digit(item.text_byte);
   assign count_inc = count_cur + 1'b1;
   assign run_hex   = run_cur && hex.found;
   assign acc_hex   = run_hex ? {acc_cur[cttap_pkg::HexWidth-5:0], hex.value} : acc_cur;

   assign glyph.glyph_code  = item.text_byte;
   assign glyph.blend_color = color_cur;
   assign glyph.flash_rate  = flash_cur;
   assign glyph.bold_on     = bold_cur;
   assign glyph.italic_on   = italic_cur;

   always_comb begin
      phase_in     = phase_cur;
      count_in     = count_cur;
      acc_in       = acc_cur;
      run_in       = run_cur;
      color_in     = color_cur;
      flash_in     = flash_cur;
      bold_in      = bold_cur;
      italic_in    = italic_cur;
      in_string_in = 1'b1;
      emit         = 1'b0;
      case (phase_cur)
         cttap_pkg::PH_NORMAL: begin
            if (item.text_byte == cttap_pkg::CH_TAB) begin
               phase_in = cttap_pkg::PH_NORMAL;
            end else if (item.text_byte == cttap_pkg::CH_CARET && parse) begin
               phase_in = cttap_pkg::PH_CARET;
            end else begin
               emit = 1'b1;
            end
         end
         cttap_pkg::PH_CARET: begin
            phase_in = cttap_pkg::PH_NORMAL;
            case (item.text_byte)
               cttap_pkg::TAG_COLOR: begin
                  phase_in = cttap_pkg::PH_COLOR;
                  count_in = '0;
                  acc_in   = '0;
                  run_in   = 1'b1;
               end
               cttap_pkg::TAG_ALPHA: begin
                  phase_in = cttap_pkg::PH_ALPHA;
                  count_in = '0;
                  acc_in   = '0;
                  run_in   = 1'b1;
               end
               cttap_pkg::TAG_FLASH: phase_in = cttap_pkg::PH_FLASH;
               cttap_pkg::TAG_RESET: begin
                  if (apply) begin
                     color_in  = default_color;
                     flash_in  = '0;
                     bold_in   = 1'b0;
                     italic_in = 1'b0;
                  end
               end
               cttap_pkg::TAG_NOP: phase_in = cttap_pkg::PH_NORMAL;
               cttap_pkg::TAG_BOLD: if (apply) bold_in = 1'b1;
               cttap_pkg::TAG_ITALIC: if (apply) italic_in = 1'b1;
               cttap_pkg::TAG_RGB_DEF: begin
                  if (apply) color_in = {default_color[31:8], color_cur[7:0]};
               end
               cttap_pkg::TAG_ALPHA_DEF: begin
                  if (apply) color_in = {color_cur[31:8], default_color[7:0]};
               end
               cttap_pkg::TAG_FLASH_OFF: if (apply) flash_in = '0;
               cttap_pkg::TAG_BOLD_OFF: if (apply) bold_in = 1'b0;
               cttap_pkg::TAG_ITAL_OFF: if (apply) italic_in = 1'b0;
               cttap_pkg::CH_CARET: emit = 1'b1;
               default: phase_in = cttap_pkg::PH_HALT;
            endcase
         end
         cttap_pkg::PH_COLOR, cttap_pkg::PH_ALPHA: begin
            acc_in   = acc_hex;
            run_in   = run_hex;
            count_in = count_inc;
            if (phase_cur == cttap_pkg::PH_COLOR && count_inc >= cttap_pkg::COLOR_DIGITS) begin
               if (apply) color_in = {acc_hex, color_cur[7:0]};
               phase_in = cttap_pkg::PH_NORMAL;
               count_in = '0;
               acc_in   = '0;
               run_in   = 1'b1;
            end else if (phase_cur == cttap_pkg::PH_ALPHA &&
                         count_inc >= cttap_pkg::ALPHA_DIGITS) begin
               if (apply) color_in = {color_cur[31:8], acc_hex[7:0]};
               phase_in = cttap_pkg::PH_NORMAL;
               count_in = '0;
               acc_in   = '0;
               run_in   = 1'b1;
            end
         end
         cttap_pkg::PH_FLASH: begin
            if (apply) flash_in = cttap_pkg::flash_of(item.text_byte);
            phase_in = cttap_pkg::PH_NORMAL;
         end
         default: phase_in = cttap_pkg::PH_HALT;
      endcase
      if (item.last) begin
         in_string_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         phase_ff     <= cttap_pkg::PH_NORMAL;
      end else if (item.step) begin
         in_string_ff <= in_string_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item.step) begin
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         run_ff    <= run_in;
         color_ff  <= color_in;
         flash_ff  <= flash_in;
         bold_ff   <= bold_in;
         italic_ff <= italic_in;
      end
   end

`ifndef SYNTH
   a_digits_bounded: assert property (@(posedge clock) disable iff (reset)
      in_string_ff && (phase_ff == cttap_pkg::PH_COLOR) |-> count_ff < cttap_pkg::COLOR_DIGITS)
      else $error("colour digit count out of range");
   a_string_closes: assert property (@(posedge clock) disable iff (reset)
      item.step && item.last |=> !in_string_ff)
      else $error("string state kept after final byte");
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      in_string_ff && (phase_ff == cttap_pkg::PH_HALT) |-> !emit)
      else $error("glyph emitted while halted");
`endif

endmodule
